// File: sv/tgp_pkg.sv
// Package for the teleinformation group parser.
// Holds the character codes, the beat class type, the queue item type and the label table.
// Depends on nothing; every other file of the block uses it.
`default_nettype none

package tgp_pkg;

   localparam logic [7:0] CHR_ETX  = 8'h03;
   localparam logic [7:0] CHR_TAB  = 8'h09;
   localparam logic [7:0] CHR_LF   = 8'h0A;
   localparam logic [7:0] CHR_CR   = 8'h0D;
   localparam logic [7:0] CHR_ZERO = 8'h30;
   localparam logic [7:0] CHR_NINE = 8'h39;

   localparam logic [5:0] SUM_BIAS   = 6'd18;
   localparam logic [7:0] CHECK_BASE = 8'd32;

   localparam logic       KIND_GROUP     = 1'b0;
   localparam logic       KIND_FRAME_END = 1'b1;

   localparam logic [1:0] TAB_MAX      = 2'd3;
   localparam logic [1:0] TAB_VALUE    = 2'd1;
   localparam logic [1:0] TAB_CHECK    = 2'd2;
   localparam logic [3:0] LABEL_LEN_MAX = 4'd15;
   localparam logic [3:0] LABEL_NONE    = 4'd0;

   localparam int QUEUE_DEPTH = 2;

   localparam int NUM_LABELS  = 9;
   localparam int MAX_LABEL   = 11;
   localparam int EXACT_LABEL = 2;

   localparam logic [3:0] LABEL_LEN [NUM_LABELS] = '{
      4'd4, 4'd4, 4'd6, 4'd6, 4'd4, 4'd5, 4'd5, 4'd4, 4'd11
   };

   // The last entry is the eleven-byte lowercase tariff-name label.
   localparam logic [7:0] LABEL_TXT [NUM_LABELS][MAX_LABEL] = '{
      '{8'h45, 8'h41, 8'h53, 8'h54, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h45, 8'h41, 8'h49, 8'h54, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h53, 8'h49, 8'h4E, 8'h53, 8'h54, 8'h53, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h53, 8'h49, 8'h4E, 8'h53, 8'h54, 8'h49, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h44, 8'h41, 8'h54, 8'h45, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h55, 8'h52, 8'h4D, 8'h53, 8'h31, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h49, 8'h52, 8'h4D, 8'h53, 8'h31, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h53, 8'h54, 8'h47, 8'h45, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h6C, 8'h69, 8'h6E, 8'h6B, 8'h79, 8'h5F, 8'h6C, 8'h74, 8'h61, 8'h72, 8'h66}
   };

   typedef enum logic [2:0] {
      CLS_OTHER,
      CLS_TAB,
      CLS_LF,
      CLS_CR,
      CLS_ETX
   } byte_class_type;

   typedef struct packed {
      byte_class_type cls;
      logic [7:0]     data;
   } item_type;

   function automatic logic [7:0] label_char(input logic [3:0] idx, input logic [3:0] pos);
      logic [7:0] c;
      c = 8'h00;
      if (idx < 4'(NUM_LABELS) && pos < 4'(MAX_LABEL)) begin
         c = LABEL_TXT[idx][pos];
      end
      return c;
   endfunction

endpackage

`default_nettype wire

// File: sv/tic_group_parser_core.sv
// Top level of the teleinformation group parser.
// Instantiates the front end, the beat queue and the back end.
// Depends on tgp_pkg, tgp_front, tgp_queue and tgp_back.
`default_nettype none

// Takes one received teleinformation character per beat and reports each
// completed group on CR (label, leading decimal value, check result, tab
// count) and each frame end on ETX. It accepts one beat every cycle while
// full is low; the rate is set by the back end, which updates the group
// state once per beat. After the CR or ETX beat is accepted, its result
// passes through the classifying register, the two-entry beat queue and
// the result register. When a result is not taken, the back end stops
// only at the next ETX or group-closing CR, and the input goes full once
// the queue and the classifying register are occupied.
module tic_group_parser_core #(
   parameter int NUMBER_WIDTH = 32
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic [7:0]              req_rx_byte,
   input  wire logic                    push,
   output logic                         full,
   output logic                         rsp_kind,
   output logic [3:0]                   rsp_label_id,
   output logic [NUMBER_WIDTH-1:0]      rsp_number,
   output logic                         rsp_number_overflow,
   output logic                         rsp_check_ok,
   output logic [1:0]                   rsp_tab_seen,
   output logic                         empty,
   input  wire logic                    pop
);

   tgp_pkg::item_type front_item;
   tgp_pkg::item_type back_item;
   logic              q_push;
   logic              q_full;
   logic              q_pop;
   logic              q_empty;

   tgp_front u_front (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .full    (full),
      .rx_byte (req_rx_byte),
      .q_item  (front_item),
      .q_push  (q_push),
      .q_full  (q_full)
   );

   tgp_queue #(
      .DEPTH (tgp_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (q_push),
      .wr_item (front_item),
      .full    (q_full),
      .rd_en   (q_pop),
      .rd_item (back_item),
      .empty   (q_empty)
   );

   tgp_back #(
      .NUMBER_WIDTH (NUMBER_WIDTH)
   ) u_back (
      .clock               (clock),
      .reset               (reset),
      .q_item              (back_item),
      .q_empty             (q_empty),
      .q_pop               (q_pop),
      .empty               (empty),
      .pop                 (pop),
      .rsp_kind            (rsp_kind),
      .rsp_label_id        (rsp_label_id),
      .rsp_number          (rsp_number),
      .rsp_number_overflow (rsp_number_overflow),
      .rsp_check_ok        (rsp_check_ok),
      .rsp_tab_seen        (rsp_tab_seen)
   );

endmodule

`default_nettype wire

// File: sv/tgp_front.sv
// Front end of the teleinformation group parser: takes beats and classifies them.
// Holds one classified beat and hands it to the decoupling queue.
// Depends on tgp_pkg.
`default_nettype none

module tgp_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   output logic                   full,
   input  wire logic [7:0]        rx_byte,
   output tgp_pkg::item_type      q_item,
   output logic                   q_push,
   input  wire logic              q_full
);

   logic                   stage_valid_ff;
   logic                   stage_valid_in;
   tgp_pkg::item_type      stage_item_ff;
   tgp_pkg::byte_class_type cls;
   logic                   take;

   always_comb begin
      unique case (rx_byte)
         tgp_pkg::CHR_ETX: cls = tgp_pkg::CLS_ETX;
         tgp_pkg::CHR_LF:  cls = tgp_pkg::CLS_LF;
         tgp_pkg::CHR_CR:  cls = tgp_pkg::CLS_CR;
         tgp_pkg::CHR_TAB: cls = tgp_pkg::CLS_TAB;
         default:          cls = tgp_pkg::CLS_OTHER;
      endcase
   end

   assign q_push = stage_valid_ff && !q_full;
   assign full   = stage_valid_ff && q_full;
   assign take   = push && !full;
   assign q_item = stage_item_ff;

   always_comb begin
      stage_valid_in = stage_valid_ff;
      if (take) begin
         stage_valid_in = 1'b1;
      end else if (q_push) begin
         stage_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         stage_item_ff.cls  <= cls;
         stage_item_ff.data <= rx_byte;
      end
   end

endmodule

`default_nettype wire

// File: sv/tgp_queue.sv
// Short queue of classified beats between the front end and the back end.
// Register-based, read from the head combinationally.
// Depends on tgp_pkg.
`default_nettype none

module tgp_queue #(
   parameter int DEPTH = 2
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              wr_en,
   input  wire tgp_pkg::item_type wr_item,
   output logic                   full,
   input  wire logic              rd_en,
   output tgp_pkg::item_type      rd_item,
   output logic                   empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   tgp_pkg::item_type  slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff;
   logic [PTR_W-1:0]   wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff;
   logic [PTR_W-1:0]   rd_ptr_in;
   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   count_in;
   logic               do_wr;
   logic               do_rd;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_wr   = wr_en && !full;
   assign do_rd   = rd_en && !empty;
   assign rd_item = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         slot_ff[wr_ptr_ff] <= wr_item;
      end
   end

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("beat queue count beyond its depth");

endmodule

`default_nettype wire

// File: sv/tgp_back.sv
// Back end of the teleinformation group parser: group state, label match, value and check.
// One classified beat per cycle, stalled by an untaken result; holds the result register.
// Depends on tgp_pkg.
`default_nettype none

module tgp_back #(
   parameter int NUMBER_WIDTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire tgp_pkg::item_type        q_item,
   input  wire logic                     q_empty,
   output logic                          q_pop,
   output logic                          empty,
   input  wire logic                     pop,
   output logic                          rsp_kind,
   output logic [3:0]                    rsp_label_id,
   output logic [NUMBER_WIDTH-1:0]       rsp_number,
   output logic                          rsp_number_overflow,
   output logic                          rsp_check_ok,
   output logic [1:0]                    rsp_tab_seen
);

   localparam int WIDE_W = NUMBER_WIDTH + 4;
   localparam int NL     = tgp_pkg::NUM_LABELS;

   logic                    in_group_ff, in_group_in;
   logic [1:0]              tab_count_ff, tab_count_in;
   logic [3:0]              label_length_ff, label_length_in;
   logic [NL-1:0]           label_alive_ff, label_alive_in;
   logic [NUMBER_WIDTH-1:0] value_accum_ff, value_accum_in;
   logic                    value_stopped_ff, value_stopped_in;
   logic                    value_saturated_ff, value_saturated_in;
   logic [5:0]              running_sum_ff, running_sum_in;
   logic [7:0]              check_char_ff, check_char_in;
   logic                    check_seen_ff, check_seen_in;

   logic                    out_valid_ff, out_valid_in;
   logic                    out_kind_ff;
   logic [3:0]              out_label_ff;
   logic [NUMBER_WIDTH-1:0] out_number_ff;
   logic                    out_overflow_ff;
   logic                    out_check_ff;
   logic [1:0]              out_tabs_ff;

   logic                    emits;
   logic                    fire;
   logic                    load_group;
   logic                    load_end;
   logic [7:0]              b;
   logic                    is_digit;
   logic [3:0]              digit;
   logic [WIDE_W-1:0]       scaled;
   logic                    too_big;
   logic [NL-1:0]           alive_next;
   logic [3:0]              match_id;
   logic [5:0]              sum_folded;
   logic [7:0]              want;

   assign b       = q_item.data;
   assign emits   = (q_item.cls == tgp_pkg::CLS_ETX) ||
                    (q_item.cls == tgp_pkg::CLS_CR && in_group_ff);
   assign fire    = !q_empty && (!emits || !out_valid_ff || pop);
   assign q_pop   = fire;
   assign load_end   = fire && (q_item.cls == tgp_pkg::CLS_ETX);
   assign load_group = fire && (q_item.cls == tgp_pkg::CLS_CR) && in_group_ff;

   assign is_digit = (b >= tgp_pkg::CHR_ZERO) && (b <= tgp_pkg::CHR_NINE);
   assign digit    = 4'(b - tgp_pkg::CHR_ZERO);
   assign scaled   = (WIDE_W'(value_accum_ff) << 3) + (WIDE_W'(value_accum_ff) << 1)
                   + WIDE_W'(digit);
   assign too_big  = |scaled[WIDE_W-1:NUMBER_WIDTH];

   always_comb begin
      alive_next = label_alive_ff;
      for (int i = 0; i < NL; i++) begin
         if (label_length_ff < tgp_pkg::LABEL_LEN[i]) begin
            if (b != tgp_pkg::label_char(4'(i), label_length_ff)) begin
               alive_next[i] = 1'b0;
            end
         end else if (i == tgp_pkg::EXACT_LABEL) begin
            alive_next[i] = 1'b0;
         end
      end
   end

   always_comb begin
      match_id = tgp_pkg::LABEL_NONE;
      for (int i = NL - 1; i >= 0; i--) begin
         if (label_alive_ff[i] && label_length_ff >= tgp_pkg::LABEL_LEN[i]) begin
            match_id = 4'(i + 1);
         end
      end
   end

   assign sum_folded = running_sum_ff + tgp_pkg::SUM_BIAS;
   assign want       = {2'b00, sum_folded} + tgp_pkg::CHECK_BASE;

   always_comb begin
      in_group_in        = in_group_ff;
      tab_count_in       = tab_count_ff;
      label_length_in    = label_length_ff;
      label_alive_in     = label_alive_ff;
      value_accum_in     = value_accum_ff;
      value_stopped_in   = value_stopped_ff;
      value_saturated_in = value_saturated_ff;
      running_sum_in     = running_sum_ff;
      check_char_in      = check_char_ff;
      check_seen_in      = check_seen_ff;
      if (fire) begin
         priority if (q_item.cls == tgp_pkg::CLS_ETX) begin
            in_group_in = 1'b0;
         end else if (q_item.cls == tgp_pkg::CLS_LF) begin
            in_group_in        = 1'b1;
            tab_count_in       = '0;
            label_length_in    = '0;
            label_alive_in     = '1;
            value_accum_in     = '0;
            value_stopped_in   = 1'b0;
            value_saturated_in = 1'b0;
            running_sum_in     = '0;
            check_char_in      = '0;
            check_seen_in      = 1'b0;
         end else if (!in_group_ff) begin
            in_group_in = 1'b0;
         end else if (q_item.cls == tgp_pkg::CLS_CR) begin
            in_group_in = 1'b0;
         end else begin
            if (tab_count_ff == tgp_pkg::TAB_CHECK && !check_seen_ff) begin
               check_char_in = b;
               check_seen_in = 1'b1;
            end
            if (q_item.cls == tgp_pkg::CLS_TAB) begin
               if (tab_count_ff != tgp_pkg::TAB_MAX) begin
                  tab_count_in = tab_count_ff + 1'b1;
               end
            end else begin
               if (tab_count_ff == '0) begin
                  label_alive_in = alive_next;
                  if (label_length_ff != tgp_pkg::LABEL_LEN_MAX) begin
                     label_length_in = label_length_ff + 1'b1;
                  end
               end else if (tab_count_ff == tgp_pkg::TAB_VALUE && !value_stopped_ff) begin
                  if (!is_digit) begin
                     value_stopped_in = 1'b1;
                  end else if (value_saturated_ff || too_big) begin
                     value_accum_in     = '1;
                     value_saturated_in = 1'b1;
                  end else begin
                     value_accum_in = scaled[NUMBER_WIDTH-1:0];
                  end
               end
               if (tab_count_ff <= tgp_pkg::TAB_VALUE) begin
                  running_sum_in = running_sum_ff + b[5:0];
               end
            end
         end
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (load_end || load_group) begin
         out_valid_in = 1'b1;
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_group_ff        <= 1'b0;
         tab_count_ff       <= '0;
         label_length_ff    <= '0;
         label_alive_ff     <= '1;
         value_accum_ff     <= '0;
         value_stopped_ff   <= 1'b0;
         value_saturated_ff <= 1'b0;
         running_sum_ff     <= '0;
         check_char_ff      <= '0;
         check_seen_ff      <= 1'b0;
         out_valid_ff       <= 1'b0;
      end else begin
         in_group_ff        <= in_group_in;
         tab_count_ff       <= tab_count_in;
         label_length_ff    <= label_length_in;
         label_alive_ff     <= label_alive_in;
         value_accum_ff     <= value_accum_in;
         value_stopped_ff   <= value_stopped_in;
         value_saturated_ff <= value_saturated_in;
         running_sum_ff     <= running_sum_in;
         check_char_ff      <= check_char_in;
         check_seen_ff      <= check_seen_in;
         out_valid_ff       <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_end) begin
         out_kind_ff     <= tgp_pkg::KIND_FRAME_END;
         out_label_ff    <= tgp_pkg::LABEL_NONE;
         out_number_ff   <= '0;
         out_overflow_ff <= 1'b0;
         out_check_ff    <= 1'b0;
         out_tabs_ff     <= '0;
      end else if (load_group) begin
         out_kind_ff     <= tgp_pkg::KIND_GROUP;
         out_label_ff    <= match_id;
         out_number_ff   <= value_accum_ff;
         out_overflow_ff <= value_saturated_ff;
         out_check_ff    <= check_seen_ff && (check_char_ff == want);
         out_tabs_ff     <= tab_count_ff;
      end
   end

   assign empty               = !out_valid_ff;
   assign rsp_kind            = out_kind_ff;
   assign rsp_label_id        = out_label_ff;
   assign rsp_number          = out_number_ff;
   assign rsp_number_overflow = out_overflow_ff;
   assign rsp_check_ok        = out_check_ff;
   assign rsp_tab_seen        = out_tabs_ff;

   a_end_closes_group: assert property (@(posedge clock) disable iff (reset)
      load_end |=> !in_group_ff)
      else $error("group still open after frame end");

   a_sat_is_max: assert property (@(posedge clock) disable iff (reset)
      value_saturated_ff |-> (value_accum_ff == '1))
      else $error("saturated value is not all ones");

   a_end_fields_clear: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_kind_ff == tgp_pkg::KIND_FRAME_END) |->
      (out_label_ff == tgp_pkg::LABEL_NONE && out_number_ff == '0 && out_tabs_ff == '0))
      else $error("frame-end result carries group fields");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !pop) |-> !(load_end || load_group))
      else $error("result register overwritten before it was taken");

endmodule

`default_nettype wire

// File: bench/tb_top.sv
// Self-checking testbench for tic_group_parser_core, the teleinformation group parser.
// Sends characters beat by beat, predicts every group and frame-end result and checks them.
// Depends on tgp_pkg and on the parser RTL.
`default_nettype none

module tb_top;

   localparam int NUM_W        = 32;
   localparam int LIMIT_CYCLES = 300000;
   localparam int RANDOM_BEATS = 1200;
   localparam int MAX_REPORTS  = 100;
   localparam int TAG_COUNT    = 9;

   localparam logic [7:0] CHR_STX = 8'h02;

   localparam logic [3:0] TAG_LEN [TAG_COUNT] = '{
      4'd4, 4'd4, 4'd6, 4'd6, 4'd4, 4'd5, 4'd5, 4'd4, 4'd11
   };

   // The last entry is the eleven-byte lowercase tariff-name label.
   localparam logic [87:0] TAG_TXT [TAG_COUNT] = '{
      "EAST", "EAIT", "SINSTS", "SINSTI", "DATE", "URMS1", "IRMS1", "STGE",
      88'h6C696E6B795F6C74617266
   };

   typedef struct packed {
      logic             kind;
      logic [3:0]       label_id;
      logic [NUM_W-1:0] number;
      logic             overflow;
      logic             check_ok;
      logic [1:0]       tab_seen;
   } group_result_type;

   logic             clock;
   logic             reset;
   logic [7:0]       req_rx_byte;
   logic             push;
   logic             full;
   logic             rsp_kind;
   logic [3:0]       rsp_label_id;
   logic [NUM_W-1:0] rsp_number;
   logic             rsp_number_overflow;
   logic             rsp_check_ok;
   logic [1:0]       rsp_tab_seen;
   logic             empty;
   logic             pop;

   group_result_type results_due [$];
   logic [7:0]       frame_beats [$];

   int cycle_count = 0;
   int mismatches  = 0;
   int sent_beats  = 0;
   int gap_max     = 14;
   int stall_max   = 0;

   // Predicted parser state.
   logic             grp_open;
   logic [1:0]       grp_tabs;
   logic [3:0]       grp_label_len;
   logic [8:0]       grp_alive;
   logic [NUM_W-1:0] grp_value;
   logic             grp_value_done;
   logic             grp_value_sat;
   logic [5:0]       grp_sum;
   logic [7:0]       grp_check;
   logic             grp_check_seen;

   logic [5:0]       stim_sum;

   tic_group_parser_core #(
      .NUMBER_WIDTH(NUM_W)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_rx_byte(req_rx_byte),
      .push(push),
      .full(full),
      .rsp_kind(rsp_kind),
      .rsp_label_id(rsp_label_id),
      .rsp_number(rsp_number),
      .rsp_number_overflow(rsp_number_overflow),
      .rsp_check_ok(rsp_check_ok),
      .rsp_tab_seen(rsp_tab_seen),
      .empty(empty),
      .pop(pop)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("Verification failed");
         $finish;
      end
   end

   function automatic logic [7:0] tag_char(input int idx, input int pos);
      return TAG_TXT[idx][8 * (int'(TAG_LEN[idx]) - 1 - pos) +: 8];
   endfunction

   function automatic logic [3:0] matched_tag();
      logic [3:0] id;
      int i;
      id = tgp_pkg::LABEL_NONE;
      for (i = TAG_COUNT - 1; i >= 0; i--) begin
         if (grp_alive[i] && grp_label_len >= TAG_LEN[i]) begin
            id = 4'(i + 1);
         end
      end
      return id;
   endfunction

   function automatic logic [7:0] check_char_for(input logic [5:0] sum);
      logic [5:0] folded;
      folded = sum + tgp_pkg::SUM_BIAS;
      return {2'b00, folded} + tgp_pkg::CHECK_BASE;
   endfunction

   task automatic clear_group();
      grp_tabs       = '0;
      grp_label_len  = '0;
      grp_alive      = '1;
      grp_value      = '0;
      grp_value_done = 1'b0;
      grp_value_sat  = 1'b0;
      grp_sum        = '0;
      grp_check      = '0;
      grp_check_seen = 1'b0;
   endtask

   task automatic take_label_char(input logic [7:0] b);
      int i;
      for (i = 0; i < TAG_COUNT; i++) begin
         if (grp_alive[i]) begin
            if (grp_label_len < TAG_LEN[i]) begin
               if (b != tag_char(i, int'(grp_label_len))) grp_alive[i] = 1'b0;
            end else if (i == tgp_pkg::EXACT_LABEL) begin
               grp_alive[i] = 1'b0;
            end
         end
      end
      if (grp_label_len != tgp_pkg::LABEL_LEN_MAX) grp_label_len++;
   endtask

   task automatic take_value_char(input logic [7:0] b);
      longint unsigned top;
      longint unsigned d;
      top = (64'd1 << NUM_W) - 1;
      if (!grp_value_done) begin
         if (b < tgp_pkg::CHR_ZERO || b > tgp_pkg::CHR_NINE) begin
            grp_value_done = 1'b1;
         end else begin
            d = 64'(b - tgp_pkg::CHR_ZERO);
            if (grp_value_sat || 64'(grp_value) > (top - d) / 10) begin
               grp_value     = NUM_W'(top);
               grp_value_sat = 1'b1;
            end else begin
               grp_value = NUM_W'(64'(grp_value) * 10 + d);
            end
         end
      end
   endtask

   // Updates the predicted state with one accepted beat and queues any result it causes.
   task automatic track_char(input logic [7:0] b);
      group_result_type r;
      r = '0;
      if (b == tgp_pkg::CHR_ETX) begin
         grp_open = 1'b0;
         r.kind   = tgp_pkg::KIND_FRAME_END;
         results_due.push_back(r);
      end else if (b == tgp_pkg::CHR_LF) begin
         grp_open = 1'b1;
         clear_group();
      end else if (grp_open) begin
         if (b == tgp_pkg::CHR_CR) begin
            grp_open   = 1'b0;
            r.kind     = tgp_pkg::KIND_GROUP;
            r.label_id = matched_tag();
            r.number   = grp_value;
            r.overflow = grp_value_sat;
            r.check_ok = grp_check_seen && grp_check == check_char_for(grp_sum);
            r.tab_seen = grp_tabs;
            results_due.push_back(r);
         end else begin
            if (grp_tabs == tgp_pkg::TAB_CHECK && !grp_check_seen) begin
               grp_check      = b;
               grp_check_seen = 1'b1;
            end
            if (b == tgp_pkg::CHR_TAB) begin
               if (grp_tabs != tgp_pkg::TAB_MAX) grp_tabs++;
            end else begin
               if (grp_tabs == 2'd0) take_label_char(b);
               else if (grp_tabs == tgp_pkg::TAB_VALUE) take_value_char(b);
               if (grp_tabs <= tgp_pkg::TAB_VALUE) grp_sum = grp_sum + b[5:0];
            end
         end
      end
   endtask

   task automatic report_mismatch(input string what, input longint unsigned got_v,
                                  input longint unsigned want_v);
      if (mismatches < MAX_REPORTS) begin
         $display("MISMATCH at cycle %0d: %s: got %0d, expected %0d",
                  cycle_count, what, got_v, want_v);
      end
      mismatches++;
   endtask

   task automatic check_result(input group_result_type got);
      group_result_type want;
      if (results_due.size() == 0) begin
         report_mismatch("result beat with nothing awaited, kind", got.kind, 0);
      end else begin
         want = results_due.pop_front();
         if (got.kind != want.kind) report_mismatch("kind", got.kind, want.kind);
         if (got.label_id != want.label_id)
            report_mismatch("label_id", got.label_id, want.label_id);
         if (got.number != want.number) report_mismatch("number", got.number, want.number);
         if (got.overflow != want.overflow)
            report_mismatch("number_overflow", got.overflow, want.overflow);
         if (got.check_ok != want.check_ok)
            report_mismatch("check_ok", got.check_ok, want.check_ok);
         if (got.tab_seen != want.tab_seen)
            report_mismatch("tab_seen", got.tab_seen, want.tab_seen);
      end
   endtask

   initial begin : result_sink
      int stall;
      group_result_type got;
      pop = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if ($urandom_range(0, 29) == 0) stall_max = (stall_max == 0) ? 14 : 0;
         stall = $urandom_range(0, stall_max);
         if (stall > 0) begin
            pop = 1'b0;
            repeat (stall) @(negedge clock);
         end
         pop = 1'b1;
         @(posedge clock);
         while (empty) @(posedge clock);
         got.kind     = rsp_kind;
         got.label_id = rsp_label_id;
         got.number   = rsp_number;
         got.overflow = rsp_number_overflow;
         got.check_ok = rsp_check_ok;
         got.tab_seen = rsp_tab_seen;
         check_result(got);
         @(negedge clock);
      end
   end

   task automatic send_char(input logic [7:0] b);
      int gap;
      if ($urandom_range(0, 39) == 0) gap_max = (gap_max == 0) ? 14 : 0;
      gap = $urandom_range(0, gap_max);
      @(negedge clock);
      if (gap > 0) begin
         push = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_rx_byte = b;
      push        = 1'b1;
      @(posedge clock);
      while (full) @(posedge clock);
      sent_beats++;
      track_char(b);
   endtask

   task automatic flush_beats();
      while (frame_beats.size() != 0) send_char(frame_beats.pop_front());
   endtask

   task automatic put_body(input logic [7:0] b);
      frame_beats.push_back(b);
      stim_sum = stim_sum + b[5:0];
   endtask

   task automatic add_label();
      int idx;
      int n;
      int k;
      int pos;
      logic [7:0] c;
      idx = $urandom_range(0, TAG_COUNT - 1);
      n   = TAG_LEN[idx];
      case ($urandom_range(0, 9))
         5: begin
            for (k = 0; k < n; k++) put_body(tag_char(idx, k));
            repeat ($urandom_range(1, 5)) put_body(8'($urandom_range(8'h21, 8'h7E)));
         end
         6: begin
            for (k = 0; k < int'($urandom_range(0, n - 1)); k++) put_body(tag_char(idx, k));
         end
         7: begin
            pos = $urandom_range(0, n - 1);
            for (k = 0; k < n; k++) begin
               c = (k == pos) ? 8'($urandom_range(8'h21, 8'h7E)) : tag_char(idx, k);
               put_body(c);
            end
         end
         8, 9: begin
            repeat ($urandom_range(0, 18)) put_body(8'($urandom_range(8'h20, 8'hFF)));
         end
         default: begin
            for (k = 0; k < n; k++) put_body(tag_char(idx, k));
         end
      endcase
   endtask

   task automatic add_value();
      string s;
      int k;
      case ($urandom_range(0, 9))
         0, 1, 2: s = $sformatf("%0d", $urandom_range(0, 99999));
         3, 4: s = $sformatf("%0d", $urandom());
         5: begin
            case ($urandom_range(0, 3))
               0: s = "4294967295";
               1: s = "4294967296";
               2: s = "4294967294";
               default: s = "429496730";
            endcase
         end
         6: begin
            s = "";
            repeat ($urandom_range(11, 22)) s = {s, $sformatf("%0d", $urandom_range(0, 9))};
         end
         7: s = $sformatf("000%0d", $urandom_range(0, 999));
         8: begin
            case ($urandom_range(0, 3))
               0: s = $sformatf("-%0d", $urandom_range(0, 9999));
               1: s = $sformatf("+%0d", $urandom_range(0, 9999));
               2: s = $sformatf(" %0d", $urandom_range(0, 9999));
               default: s = $sformatf("%0dA%0d", $urandom_range(0, 99), $urandom_range(0, 99));
            endcase
         end
         default: s = "";
      endcase
      for (k = 0; k < s.len(); k++) put_body(s[k]);
   endtask

   // Mostly a correct group; the shape draw leaves out fields, spoils the check character or adds a field.
   task automatic send_group();
      int shape;
      if ($urandom_range(0, 14) == 0) begin
         frame_beats.push_back(tgp_pkg::CHR_LF);
         repeat ($urandom_range(0, 4)) frame_beats.push_back(8'($urandom_range(8'h20, 8'h7E)));
      end
      stim_sum = '0;
      frame_beats.push_back(tgp_pkg::CHR_LF);
      add_label();
      shape = $urandom_range(0, 19);
      if (shape != 0) begin
         frame_beats.push_back(tgp_pkg::CHR_TAB);
         add_value();
         if (shape != 1) begin
            frame_beats.push_back(tgp_pkg::CHR_TAB);
            case (shape)
               2: ;
               3: frame_beats.push_back(8'($urandom_range(0, 255)));
               4: frame_beats.push_back(check_char_for(stim_sum) + 8'd1);
               default: frame_beats.push_back(check_char_for(stim_sum));
            endcase
            if (shape == 5) begin
               frame_beats.push_back(tgp_pkg::CHR_TAB);
               frame_beats.push_back(8'($urandom_range(8'h20, 8'h7E)));
            end
         end
      end
      frame_beats.push_back(tgp_pkg::CHR_CR);
      if ($urandom_range(0, 11) == 0) frame_beats.push_back(tgp_pkg::CHR_ETX);
      if ($urandom_range(0, 9) == 0) begin
         repeat ($urandom_range(1, 3)) frame_beats.push_back(8'($urandom_range(0, 255)));
      end
      flush_beats();
   endtask

   task automatic test_outside_group();
      send_char(8'h00);
      send_char(8'hFF);
      send_char(tgp_pkg::CHR_CR);
      send_char(CHR_STX);
      send_char(tgp_pkg::CHR_ETX);
   endtask

   task automatic test_group_restart();
      send_char(tgp_pkg::CHR_LF);
      send_char("E");
      send_char("A");
      send_char(tgp_pkg::CHR_LF);
      send_char(tgp_pkg::CHR_TAB);
      send_char("-");
      send_char("7");
      send_char(tgp_pkg::CHR_TAB);
      send_char(tgp_pkg::CHR_CR);
   endtask

   task automatic test_tab_as_check_char();
      send_char(tgp_pkg::CHR_LF);
      send_char(CHR_STX);
      send_char(tgp_pkg::CHR_TAB);
      send_char(tgp_pkg::CHR_TAB);
      send_char(tgp_pkg::CHR_TAB);
      send_char(8'hFF);
      send_char(tgp_pkg::CHR_CR);
   endtask

   task automatic test_frame_end_in_group();
      send_char(tgp_pkg::CHR_LF);
      send_char("D");
      send_char(tgp_pkg::CHR_ETX);
   endtask

   task automatic test_well_formed_groups();
      while (sent_beats < RANDOM_BEATS * 4 / 5) send_group();
   endtask

   task automatic test_noise();
      logic [7:0] b;
      while (sent_beats < RANDOM_BEATS) begin
         case ($urandom_range(0, 15))
            8, 9: b = 8'($urandom_range(tgp_pkg::CHR_ZERO, tgp_pkg::CHR_NINE));
            10: b = tgp_pkg::CHR_LF;
            11, 12: b = tgp_pkg::CHR_TAB;
            13: b = tgp_pkg::CHR_CR;
            14: b = tgp_pkg::CHR_ETX;
            15: b = 8'($urandom_range("A", "Z"));
            default: b = 8'($urandom_range(0, 255));
         endcase
         send_char(b);
      end
   endtask

   initial begin
      reset       = 1'b1;
      push        = 1'b0;
      req_rx_byte = '0;
      grp_open    = 1'b0;
      clear_group();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_outside_group();
      test_group_restart();
      test_tab_as_check_char();
      test_frame_end_in_group();
      test_well_formed_groups();
      test_noise();

      @(negedge clock);
      push = 1'b0;
      while (results_due.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatches == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

`default_nettype wire

// File: sim.f
sv/tgp_pkg.sv
sv/tgp_front.sv
sv/tgp_queue.sv
sv/tgp_back.sv
sv/tic_group_parser_core.sv
bench/tb_top.sv
